### sv/rcan_pkg.sv
// Package: widths, codes, gamma and weight tables for the cone normalizer.
package rcan_pkg;

	localparam int MaxPixels = 16384;
	localparam int FracBits = 15;
	localparam int AddrW = $clog2(MaxPixels);
	localparam int CountW = AddrW + 1;
	localparam int ActW = FracBits + 1;
	localparam logic [ActW-1:0] OneFx = ActW'(1 << FracBits);

	typedef enum logic [1:0] {
		CONE_LONG  = 2'd0,
		CONE_MED   = 2'd1,
		CONE_SHORT = 2'd2,
		CONE_ALT   = 2'd3
	} cone_t;

	typedef enum logic {
		REG_CONE  = 1'b0,
		REG_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_STORE,
		ST_FETCH,
		ST_DIV,
		ST_OUT
	} state_t;

	// Divider control between sequencer and divider.
	typedef struct packed {
		logic start;
		logic [ActW-1:0] dividend;
		logic [ActW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [ActW-1:0] quotient;
	} div_rsp_t;

	localparam logic [31:0] GammaMicro [256] = '{
		0, 5, 23, 57, 107, 175, 262, 367, 493, 638,
		805, 992, 1202, 1433, 1687, 1963, 2263, 2586, 2932, 3303,
		3697, 4116, 4560, 5028, 5522, 6041, 6585, 7155, 7751, 8373,
		9021, 9696, 10398, 11126, 11881, 12664, 13473, 14311, 15175, 16068,
		16988, 17936, 18913, 19918, 20951, 22013, 23104, 24223, 25371, 26549,
		27755, 28991, 30257, 31551, 32876, 34230, 35614, 37029, 38473, 39947,
		41452, 42987, 44553, 46149, 47776, 49433, 51122, 52842, 54592, 56374,
		58187, 60032, 61907, 63815, 65754, 67725, 69727, 71761, 73828, 75926,
		78057, 80219, 82414, 84642, 86901, 89194, 91518, 93876, 96266, 98689,
		101145, 103634, 106156, 108711, 111299, 113921, 116576, 119264, 121986, 124741,
		127530, 130352, 133209, 136099, 139022, 141980, 144972, 147998, 151058, 154152,
		157281, 160444, 163641, 166872, 170138, 173439, 176774, 180144, 183549, 186989,
		190463, 193972, 197516, 201096, 204710, 208360, 212044, 215764, 219520, 223310,
		227137, 230998, 234895, 238828, 242796, 246800, 250840, 254916, 259027, 263175,
		267358, 271577, 275833, 280124, 284452, 288816, 293216, 297653, 302125, 306635,
		311180, 315763, 320382, 325037, 329729, 334458, 339223, 344026, 348865, 353741,
		358654, 363604, 368591, 373615, 378676, 383775, 388910, 394083, 399293, 404541,
		409826, 415148, 420508, 425905, 431340, 436813, 442323, 447871, 453456, 459080,
		464741, 470440, 476177, 481952, 487765, 493616, 499505, 505432, 511398, 517401,
		523443, 529523, 535642, 541798, 547994, 554227, 560499, 566810, 573159, 579547,
		585973, 592438, 598942, 605484, 612066, 618686, 625345, 632043, 638779, 645555,
		652370, 659224, 666117, 673049, 680020, 687031, 694081, 701170, 708298, 715465,
		722672, 729919, 737205, 744530, 751895, 759300, 766744, 774227, 781751, 789314,
		796917, 804559, 812241, 819964, 827726, 835528, 843370, 851252, 859174, 867136,
		875138, 883180, 891262, 899385, 907547, 915750, 923993, 932277, 940601, 948965,
		957370, 965815, 974300, 982826, 991393, 1000000
	};

	localparam logic [31:0] WeightNano [9] = '{
		287745593, 547419113, 164829943,
		113986511, 623551157, 262465287,
		15628637, 55945904, 928446918
	};

	// Gamma ROM entry in UQ1.FracBits, rounded half up.
	function automatic logic [ActW-1:0] gamma_fx(input logic [7:0] code);
		logic [63:0] v;
		v = ((64'(GammaMicro[code]) << FracBits) + 64'd500000) / 64'd1000000;
		return v[ActW-1:0];
	endfunction

	function automatic logic [ActW-1:0] weight_fx(input logic [3:0] idx);
		logic [63:0] v;
		v = ((64'(WeightNano[idx]) << FracBits) + 64'd500000000) / 64'd1000000000;
		return v[ActW-1:0];
	endfunction

	// Whole tables, evaluated at elaboration.
	function automatic logic [255:0][ActW-1:0] gamma_table();
		logic [255:0][ActW-1:0] t;
		for (int i = 0; i < 256; i++) t[i] = gamma_fx(8'(i));
		return t;
	endfunction

	function automatic logic [8:0][ActW-1:0] weight_table();
		logic [8:0][ActW-1:0] t;
		for (int i = 0; i < 9; i++) t[i] = weight_fx(4'(i));
		return t;
	endfunction

	localparam logic [255:0][ActW-1:0] GammaFx = gamma_table();
	localparam logic [8:0][ActW-1:0] WeightFx = weight_table();

endpackage

### sv/rcan_div.sv
// Restoring divider: one quotient bit per cycle, shared by every read.
module rcan_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcan_pkg::div_req_t      req,
	output rcan_pkg::div_rsp_t      rsp
);
	localparam int W = rcan_pkg::ActW;
	localparam int NumW = W + rcan_pkg::FracBits;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [W:0]      trial;
	logic [W+1:0]    diff;

	// Shift in the next numerator bit and try a subtract.
	always_comb begin
		trial = {rem_q, num_q[NumW-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rsp    <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q       <= 1'b0;
					rsp.done     <= 1'b1;
					// Zero peak yields zero; quotient never exceeds ONE.
					rsp.quotient <= (den_q == '0) ? '0 :
						{num_q[W-2:0], ~diff[W+1]};
				end
			end
		end
	end

	// Datapath registers; the remainder stays below the divisor.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {req.dividend, {rcan_pkg::FracBits{1'b0}}};
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= diff[W+1] ? trial[W-1:0] : diff[W-1:0];
			num_q <= {num_q[NumW-2:0], ~diff[W+1]};
		end
	end
endmodule

### sv/rgb_cone_activation_normalizer.sv
// Top level: gamma and cone weighting with a shared MAC, frame store, shared divider.
// Load: transfer cycle, three MAC steps on one multiplier, one store write.
// Read: transfer, store read into the read register, then the 31-step bit-serial
// divider, whose quotient goes to the output.
// One item at a time; a result waits in the output register until taken.
// Reset (arst_n, asynchronous): cone_kind long, pixel_count 16384, empty frame,
// peak zero. The activation store is not cleared; only written entries are read.
module rgb_cone_activation_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] activation,
	output logic        last
);
	localparam int AW = rcan_pkg::AddrW;
	localparam int CW = rcan_pkg::CountW;
	localparam int W = rcan_pkg::ActW;
	localparam int PW = 2 * W;

	rcan_pkg::state_t state_q, state_d;
	rcan_pkg::cone_t  cone_q;
	logic [14:0]      pcount_q;
	logic [W-1:0]     peak_q;
	logic [CW-1:0]    load_q;
	logic [AW-1:0]    rptr_q;
	logic [1:0]       step_q;
	logic [7:0]       r_q, g_q, b_q;
	logic [PW+1:0]    acc_q;
	logic [W-1:0]     mem [rcan_pkg::MaxPixels];
	logic [W-1:0]     rd_q;
	logic             last_q;
	logic [W-1:0]     act_fix;
	logic [CW-1:0]    frame_n;
	logic             complete;
	logic [7:0]       code;
	logic [3:0]       widx;
	logic [1:0]       krow;
	logic [PW-1:0]    prod;
	logic [PW+1:0]    rnd;
	logic             do_in;
	rcan_pkg::div_req_t dreq;
	rcan_pkg::div_rsp_t drsp;

	// Effective frame size: zero means one, clamp to store depth.
	always_comb begin
		if (pcount_q == '0) frame_n = CW'(1);
		else if (CW'(pcount_q) > CW'(rcan_pkg::MaxPixels)) frame_n = CW'(rcan_pkg::MaxPixels);
		else frame_n = CW'(pcount_q);
	end
	assign complete = load_q >= frame_n;

	assign cfg_ready = (state_q == rcan_pkg::ST_IDLE);
	assign in_ready  = (state_q == rcan_pkg::ST_IDLE);
	assign do_in     = in_valid && in_ready;

	// Shared multiplier operands: one channel per MAC step.
	always_comb begin
		krow = (cone_q == rcan_pkg::CONE_ALT) ? 2'd2 : cone_q;
		unique case (step_q)
			2'd0:    code = r_q;
			2'd1:    code = g_q;
			default: code = b_q;
		endcase
		widx = 4'(krow) * 4'd3 + 4'(step_q);
		prod = rcan_pkg::GammaFx[code] * rcan_pkg::WeightFx[widx];
		rnd  = (acc_q + (PW+2)'(1 << (rcan_pkg::FracBits - 1))) >> rcan_pkg::FracBits;
		act_fix = (rnd > (PW+2)'(rcan_pkg::OneFx)) ? rcan_pkg::OneFx : rnd[W-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcan_pkg::ST_IDLE:
				if (do_in) begin
					if (operation == rcan_pkg::OP_LOAD)
						state_d = (!complete && load_q < CW'(rcan_pkg::MaxPixels))
							? rcan_pkg::ST_MAC : rcan_pkg::ST_IDLE;
					else
						state_d = complete ? rcan_pkg::ST_FETCH : rcan_pkg::ST_IDLE;
				end
			rcan_pkg::ST_MAC:   if (step_q == 2'd2) state_d = rcan_pkg::ST_STORE;
			rcan_pkg::ST_STORE: state_d = rcan_pkg::ST_IDLE;
			rcan_pkg::ST_FETCH: state_d = rcan_pkg::ST_DIV;
			rcan_pkg::ST_DIV:   if (drsp.done) state_d = rcan_pkg::ST_OUT;
			rcan_pkg::ST_OUT:   if (out_ready) state_d = rcan_pkg::ST_IDLE;
			default:            state_d = rcan_pkg::ST_IDLE;
		endcase
	end

	// Outputs and divider request.
	always_comb begin
		out_valid     = (state_q == rcan_pkg::ST_OUT);
		activation    = drsp.quotient;
		last          = last_q;
		dreq.start    = 1'b0;
		dreq.dividend = rd_q;
		dreq.divisor  = peak_q;
		if (state_q == rcan_pkg::ST_FETCH) dreq.start = 1'b1;
	end

	// Activation store and read register.
	always_ff @(posedge clk) begin
		if (state_q == rcan_pkg::ST_STORE) mem[load_q[AW-1:0]] <= act_fix;
		rd_q <= mem[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_in) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
		end
	end

	// Control and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rcan_pkg::ST_IDLE;
			cone_q   <= rcan_pkg::CONE_LONG;
			pcount_q <= 15'd16384;
			peak_q   <= '0;
			load_q   <= '0;
			rptr_q   <= '0;
			step_q   <= '0;
			acc_q    <= '0;
			last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rcan_pkg::REG_CONE) cone_q <= rcan_pkg::cone_t'(cfg_data[1:0]);
				else pcount_q <= cfg_data;
			end
			if (do_in) begin
				step_q <= '0;
				acc_q  <= '0;
				last_q <= (CW'(rptr_q) + CW'(1)) >= frame_n;
			end
			if (state_q == rcan_pkg::ST_MAC) begin
				acc_q  <= acc_q + (PW+2)'(prod);
				step_q <= step_q + 2'd1;
			end
			if (state_q == rcan_pkg::ST_STORE) begin
				if (act_fix > peak_q) peak_q <= act_fix;
				load_q <= load_q + CW'(1);
			end
			if (state_q == rcan_pkg::ST_OUT && out_ready) begin
				if (last_q) begin
					load_q <= '0;
					rptr_q <= '0;
					peak_q <= '0;
				end else begin
					rptr_q <= rptr_q + AW'(1);
				end
			end
		end
	end

	rcan_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

`ifndef SYNTH
	// Quotient is normalized, so it never exceeds one.
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> activation <= rcan_pkg::OneFx) else $error("activation above one");
	// Peak never below the value just stored.
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rcan_pkg::ST_STORE |=> peak_q >= $past(act_fix))
		else $error("peak not tracked");
	// Divider finishes only while the read waits on it.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == rcan_pkg::ST_DIV) else $error("stray divider done");
`endif
endmodule

### sim/tb_rgb_cone_activation_normalizer.sv
// Testbench for the cone activation normalizer: scoreboard, stimulus, checks.

class activation_scoreboard;
	logic [15:0] act_store [rcan_pkg::MaxPixels];
	logic [15:0] peak;
	int unsigned loaded;
	int unsigned rd_ptr;
	logic [1:0] cone;
	logic [14:0] frame_len;
	logic [15:0] exp_act [$];
	logic exp_last [$];
	int errors;

	function new();
		peak = 0;
		loaded = 0;
		rd_ptr = 0;
		cone = rcan_pkg::CONE_LONG;
		frame_len = 15'd16384;
		errors = 0;
	endfunction

	// Gamma ROM value in UQ1.15, rounded half up
	function longint unsigned gamma_q(logic [7:0] code);
		longint unsigned g;
		g = rcan_pkg::GammaMicro[code];
		return ((g << rcan_pkg::FracBits) + 64'd500000) / 64'd1000000;
	endfunction

	function longint unsigned weight_q(int idx);
		longint unsigned w;
		w = rcan_pkg::WeightNano[idx];
		return ((w << rcan_pkg::FracBits) + 64'd500000000) / 64'd1000000000;
	endfunction

	function int unsigned eff_count();
		if (frame_len == 0) return 1;
		if (frame_len > rcan_pkg::MaxPixels) return rcan_pkg::MaxPixels;
		return frame_len;
	endfunction

	function bit complete();
		return loaded >= eff_count();
	endfunction

	function void write_reg(logic idx, logic [14:0] data);
		if (idx == rcan_pkg::REG_CONE) cone = data[1:0];
		else frame_len = data;
	endfunction

	// Note an accepted input and queue any result it causes
	function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		longint unsigned sum, a, q;
		int k;
		if (op == rcan_pkg::OP_LOAD) begin
			if (complete() || loaded >= rcan_pkg::MaxPixels) return;
			k = (cone == rcan_pkg::CONE_ALT) ? 2 : int'(cone);
			sum = gamma_q(r) * weight_q(k * 3) + gamma_q(g) * weight_q(k * 3 + 1)
				+ gamma_q(b) * weight_q(k * 3 + 2);
			a = (sum + (64'd1 << (rcan_pkg::FracBits - 1))) >> rcan_pkg::FracBits;
			if (a > (64'd1 << rcan_pkg::FracBits)) a = 64'd1 << rcan_pkg::FracBits;
			act_store[loaded] = a[15:0];
			if (a[15:0] > peak) peak = a[15:0];
			loaded++;
			return;
		end
		if (!complete() || rd_ptr >= rcan_pkg::MaxPixels) return;
		a = act_store[rd_ptr];
		q = (peak != 0) ? (a << rcan_pkg::FracBits) / peak : 0;
		exp_act.push_back(q[15:0]);
		if (rd_ptr + 1 >= eff_count()) begin
			exp_last.push_back(1'b1);
			loaded = 0;
			rd_ptr = 0;
			peak = 0;
		end else begin
			exp_last.push_back(1'b0);
			rd_ptr++;
		end
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(logic [15:0] act, logic lst);
		logic [15:0] ea;
		logic el;
		if (exp_act.size() == 0) begin
			report("unexpected result", act, -1);
			return;
		end
		ea = exp_act.pop_front();
		el = exp_last.pop_front();
		if (act !== ea) report("activation", act, ea);
		if (lst !== el) report("last", lst, el);
	endtask
endclass

module tb_rgb_cone_activation_normalizer;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = rcan_pkg::REG_CONE;
	logic [14:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = rcan_pkg::OP_LOAD;
	logic [7:0] red = '0, green = '0, blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] activation;
	logic last;

	activation_scoreboard sb = new();
	int idle_cycles = 0;
	int rx_hold = 0;
	bit rx_steady = 1'b0;
	int burst_left = 0;
	bit in_active = 1'b0;

	rgb_cone_activation_normalizer dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: check every transfer, stall on its own pattern
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(activation, last);
		if (rx_hold > 0) out_ready <= 1'b0;
		else if (rx_steady) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_rgb_cone_activation_normalizer failed");
			$finish;
		end
	end

	// Long receiver hold-off, counted here
	task automatic hold_receiver(int n);
		rx_hold = n;
		while (rx_hold > 0) begin
			@(posedge clk);
			rx_hold--;
		end
	endtask

	// Drop the input valid once the sender stops offering
	task automatic idle_sender();
		if (in_active) begin
			in_valid <= 1'b0;
			in_active = 1'b0;
		end
	endtask

	task automatic write_cfg(logic idx, logic [14:0] data);
		idle_sender();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drive one item, with bursts and gaps on the sender side
	task automatic send(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				idle_sender();
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		in_active = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(op, r, g, b);
	endtask

	// Wait until idle; a load may still be in progress after last result
	task automatic drain();
		idle_sender();
		while (sb.exp_act.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_pixel();
		send(rcan_pkg::OP_LOAD, $urandom, $urandom, $urandom);
	endtask

	// One frame: loads then reads, with some stray items mixed in
	task automatic frame_run(bit noisy);
		int n;
		n = sb.eff_count();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send(rcan_pkg::OP_READ, $urandom, $urandom, $urandom);
			random_pixel();
		end
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0) random_pixel();
			send(rcan_pkg::OP_READ, $urandom, $urandom, $urandom);
		end
		idle_sender();
	endtask

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes per cone, zero peak, read before complete, load when full
		write_cfg(rcan_pkg::REG_COUNT, 15'd3);
		for (int c = 0; c < 4; c++) begin
			write_cfg(rcan_pkg::REG_CONE, c[14:0]);
			send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
			send(rcan_pkg::OP_LOAD, 8'hff, 8'hff, 8'hff);
			send(rcan_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00);
			send(rcan_pkg::OP_LOAD, 8'hff, 8'h00, 8'h80);
			send(rcan_pkg::OP_LOAD, 8'h55, 8'haa, 8'h01);
			send(rcan_pkg::OP_READ, 8'hff, 8'hff, 8'hff);
			send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
			send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
			drain();
		end
		write_cfg(rcan_pkg::REG_COUNT, 15'd2);
		send(rcan_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00);
		send(rcan_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00);
		send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
		send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
		drain();
		write_cfg(rcan_pkg::REG_COUNT, 15'd0);
		send(rcan_pkg::OP_LOAD, 8'h12, 8'h34, 8'h56);
		send(rcan_pkg::OP_READ, 8'h00, 8'h00, 8'h00);
		drain();
		write_cfg(rcan_pkg::REG_COUNT, 15'd1);
		frame_run(1'b0);
		drain();

		// Receiver held off while the sender keeps offering
		write_cfg(rcan_pkg::REG_COUNT, 15'd6);
		fork
			hold_receiver(400);
			frame_run(1'b0);
		join
		drain();

		// Random frames of small sizes, varying cone
		sent = 0;
		while (sent < 920) begin
			write_cfg(rcan_pkg::REG_CONE, 15'($urandom_range(0, 3)));
			write_cfg(rcan_pkg::REG_COUNT, 15'($urandom_range(1, 24)));
			rx_steady = ($urandom_range(0, 4) == 0);
			frame_run(1'b1);
			sent += 2 * sb.eff_count();
			if ($urandom_range(0, 3) == 0) drain();
		end
		drain();
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.exp_act.size() == 0)
			$display("tb_rgb_cone_activation_normalizer passed");
		else
			$display("tb_rgb_cone_activation_normalizer failed");
		$finish;
	end
endmodule
